// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define A85_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define A85_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/a85_pkg.sv =====
// shared types and constants of the ascii85 stream decoder
// no dependencies
package a85_pkg;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_END   = 2'd1,
        ST_BAD   = 2'd2,
        ST_EARLY = 2'd3
    } status_t;

    // one decoded step as handed from front to back
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        status_t     status;
    } cmd_t;

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_U     = 8'h75;
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    localparam logic [19:0] DIGIT_BASE = 20'd85;

    // padding with 'u' digits: (v + 1) * 85^k - 1, k = 5 - count
    function automatic logic [19:0] pad_power(input logic [2:0] count);
        logic [19:0] p;
        case (count)
            3'd2:    p = 20'd614125;
            3'd3:    p = 20'd7225;
            default: p = 20'd85;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/a85_front.sv =====
// front end: accepts characters, classifies them and keeps the group state
// depends on a85_pkg
module a85_front
    import a85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_end,
    input  logic       q_full,
    output logic       q_push,
    output cmd_t       q_wdata
);

    logic [31:0] value_reg, value_next;
    logic [2:0]  count_reg, count_next;
    logic        tilde_reg, tilde_next;
    logic        marker_reg, marker_next;
    logic        finished_reg, finished_next;

    logic        accept;
    logic [6:0]  dig;
    logic [31:0] mul_a;
    logic [19:0] mul_b;
    logic [31:0] prod;
    logic [31:0] addend;
    logic [31:0] word;
    logic [31:0] out_word;
    logic [2:0]  nb;
    status_t     st;
    logic        is_blank;
    logic        is_digit;
    logic        emit;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign dig = 7'(in_char - CHAR_BANG);

    // one multiplier serves both the digit step and the end padding
    assign mul_a  = tilde_reg ? (value_reg + 32'd1) : value_reg;
    assign mul_b  = tilde_reg ? pad_power(count_reg) : DIGIT_BASE;
    assign addend = tilde_reg ? 32'hFFFF_FFFF : {25'd0, dig};
    assign prod   = mul_a * {12'd0, mul_b};
    assign word   = prod + addend;

    assign is_digit = (in_char >= CHAR_BANG) && (in_char <= CHAR_U);

    always_comb
    begin
        is_blank = 1'b0;
        case (in_char) inside
            8'h00, 8'h09, 8'h0A, 8'h0C, 8'h0D, 8'h20: is_blank = 1'b1;
            default:                                  is_blank = 1'b0;
        endcase
    end

    always_comb
    begin
        value_next    = value_reg;
        count_next    = count_reg;
        tilde_next    = tilde_reg;
        marker_next   = marker_reg;
        finished_next = finished_reg;
        nb            = 3'd0;
        st            = ST_OK;
        out_word      = word;

        if (is_blank)
        begin
        end
        else if (marker_reg)
        begin
            st = ST_BAD;
        end
        else if (tilde_reg)
        begin
            tilde_next = 1'b0;
            if (in_char == CHAR_GT)
            begin
                marker_next = 1'b1;
                if (count_reg >= 3'd2)
                begin
                    nb = count_reg - 3'd1;
                end
                value_next = 32'd0;
                count_next = 3'd0;
            end
            else
            begin
                st = ST_BAD;
            end
        end
        else if (in_char == CHAR_TILDE)
        begin
            tilde_next = 1'b1;
        end
        else if (in_char == CHAR_Z && count_reg == 3'd0)
        begin
            out_word = 32'd0;
            nb       = 3'd4;
        end
        else if (is_digit)
        begin
            if (count_reg == 3'd4)
            begin
                nb         = 3'd4;
                value_next = 32'd0;
                count_next = 3'd0;
            end
            else
            begin
                value_next = word;
                count_next = count_reg + 3'd1;
            end
        end
        else
        begin
            st = ST_BAD;
        end

        if (st == ST_OK && in_end)
        begin
            st = marker_next ? ST_END : ST_EARLY;
        end
        if (st != ST_OK)
        begin
            finished_next = 1'b1;
        end
    end

    assign emit           = (nb != 3'd0) || (st != ST_OK);
    assign q_push         = accept && !finished_reg && emit;
    assign q_wdata.word   = out_word;
    assign q_wdata.nbytes = nb;
    assign q_wdata.status = st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg    <= 32'd0;
            count_reg    <= 3'd0;
            tilde_reg    <= 1'b0;
            marker_reg   <= 1'b0;
            finished_reg <= 1'b0;
        end
        else if (accept && !finished_reg)
        begin
            value_reg    <= value_next;
            count_reg    <= count_next;
            tilde_reg    <= tilde_next;
            marker_reg   <= marker_next;
            finished_reg <= finished_next;
        end
    end

endmodule

// ===== hw/rtl/a85_queue.sv =====
// short command queue between front and back
// depends on a85_pkg
module a85_queue
    import a85_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t wdata,
    input  logic pop,
    output cmd_t rdata,
    output logic full,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/a85_back.sv =====
// back end: turns queued commands into one result transfer per cycle while out_ready is high
// depends on a85_pkg
module a85_back
    import a85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       q_rdata,
    input  logic       q_empty,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [1:0] status,
    output logic       last
);

    cmd_t       cmd_reg;
    logic [1:0] idx_reg;
    logic       busy_reg;
    logic       xfer;

    assign out_valid  = busy_reg;
    assign byte_valid = (cmd_reg.nbytes != 3'd0);
    assign status     = cmd_reg.status;
    assign last       = !byte_valid || ({1'b0, idx_reg} == (cmd_reg.nbytes - 3'd1));
    assign xfer       = out_valid && out_ready;
    assign q_pop      = !q_empty && (!busy_reg || (xfer && last));

    // most significant byte first
    always_comb
    begin
        out_byte = 8'd0;
        if (byte_valid)
        begin
            case (idx_reg)
                2'd0:    out_byte = cmd_reg.word[31:24];
                2'd1:    out_byte = cmd_reg.word[23:16];
                2'd2:    out_byte = cmd_reg.word[15:8];
                default: out_byte = cmd_reg.word[7:0];
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_rdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= 2'd0;
        end
        else if (q_pop)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= 2'd0;
        end
        else if (xfer && last)
        begin
            busy_reg <= 1'b0;
        end
        else if (xfer)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

endmodule

// ===== hw/rtl/ascii85_stream_decoder_top.sv =====
// ascii85 stream decoder: takes one encoded character per transfer and gives decoded
// bytes with status. A character is taken whenever the command queue (QUEUE_DEPTH
// entries) has room; results leave at one per cycle while out_ready is high, so a 'z'
// or a group-ending digit holds the output port for its four bytes. A result passes
// through the queue memory and the back-end command register before it reaches the
// output.
// depends on a85_pkg, a85_front, a85_queue, a85_back
module ascii85_stream_decoder_top
    import a85_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       in_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic [1:0] status,
    output logic       last
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    cmd_t q_wdata;
    cmd_t q_rdata;

    a85_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_char  (in_char),
        .in_end   (in_end),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    a85_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    a85_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_rdata    (q_rdata),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .status     (status),
        .last       (last)
    );

endmodule

// ===== hw/rtl/a85_checker.sv =====
// port-level checks on the result channel of the decoder, bound to the top level
// depends on a85_pkg and assert_macros.svh
`include "assert_macros.svh"

module a85_checker
    import a85_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic [1:0] status,
    input logic       last
);

    logic        stall;
    logic [10:0] res_bits;
    logic        lone_ok;
    logic        mid_xfer;
    logic        burst_on;

    assign stall    = out_valid && !out_ready;
    assign res_bits = {out_byte, status, last};
    assign lone_ok  = last && (status != ST_OK) && (out_byte == 8'd0);
    assign mid_xfer = out_valid && out_ready && !last;
    assign burst_on = out_valid && byte_valid;

    // stalled result holds
    `A85_ASSERT_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(res_bits))

    // a result without a byte is a lone status report
    `A85_ASSERT_SAME(a_status_only, clk, rst_n, out_valid && !byte_valid, lone_ok)

    // plain ok results always carry a byte
    `A85_ASSERT_SAME(a_ok_has_byte, clk, rst_n, out_valid && (status == ST_OK), byte_valid)

    // bytes of one character follow back to back with the same status
    `A85_ASSERT_NEXT(a_step_burst, clk, rst_n, mid_xfer, burst_on && $stable(status))

endmodule

bind ascii85_stream_decoder_top a85_checker u_checker (.*);
